/* rtl/tmcw_pkg.sv */
// Shared types and constants for the text mode console writer.
// Holds request/result payload structs, function codes and plan flags.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tmcw_pkg;

  localparam int unsigned COLUMNS_DEF = 80;
  localparam int unsigned ROWS_DEF    = 25;

  localparam int unsigned FUNC_W    = 2;
  localparam int unsigned COL_FLD_W = 7;
  localparam int unsigned ROW_FLD_W = 5;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned CELL_W    = 2 * BYTE_W;

  localparam logic [BYTE_W-1:0] BLANK_CHAR = 8'h20;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_PRINT  = 2'd0,
    FUNC_WRITE  = 2'd1,
    FUNC_CURSOR = 2'd2,
    FUNC_READ   = 2'd3
  } func_e;

  typedef struct packed {
    logic [FUNC_W-1:0]    func;
    logic [COL_FLD_W-1:0] column;
    logic [ROW_FLD_W-1:0] row;
    logic [BYTE_W-1:0]    char_code;
    logic [BYTE_W-1:0]    attribute;
    logic                 last_char;
  } in_item_t;

  typedef struct packed {
    logic [COL_FLD_W-1:0] cursor_col;
    logic [ROW_FLD_W-1:0] cursor_row;
    logic [BYTE_W-1:0]    cell_char;
    logic [BYTE_W-1:0]    cell_attr;
    logic                 done_res;
  } out_item_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
    logic scroll;
    logic done;
  } plan_t;

endpackage

`default_nettype wire

/* rtl/tmcw_plan.sv */
// Request decoder: cell address, write data, next cursor and access flags.
// Depends on tmcw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tmcw_plan #(
  parameter int unsigned COLUMNS = tmcw_pkg::COLUMNS_DEF,
  parameter int unsigned ROWS    = tmcw_pkg::ROWS_DEF
) (
  input  tmcw_pkg::in_item_t                    item_i,
  input  logic [$clog2(COLUMNS+1)-1:0]          cur_col_i,
  input  logic [$clog2(ROWS)-1:0]               cur_row_i,
  output tmcw_pkg::plan_t                       plan_o,
  output logic [$clog2(COLUMNS*ROWS)-1:0]       addr_o,
  output logic [tmcw_pkg::CELL_W-1:0]           wr_data_o,
  output logic [$clog2(COLUMNS+1)-1:0]          nxt_col_o,
  output logic [$clog2(ROWS)-1:0]               nxt_row_o
);
  import tmcw_pkg::*;

  localparam int unsigned CCOL_W = $clog2(COLUMNS + 1);
  localparam int unsigned CROW_W = $clog2(ROWS);
  localparam int unsigned IDX_W  = $clog2(COLUMNS * ROWS);

  logic              wrap;
  logic              last_row;
  logic              on_screen;
  logic [CCOL_W-1:0] pcol;
  logic [CROW_W-1:0] prow;
  logic [IDX_W-1:0]  sel_col;
  logic [IDX_W-1:0]  sel_row;

  assign wrap      = (cur_col_i == CCOL_W'(COLUMNS));
  assign last_row  = (cur_row_i == CROW_W'(ROWS - 1));
  assign on_screen = (item_i.column < COLUMNS) && (item_i.row < ROWS);
  assign pcol      = wrap ? '0 : cur_col_i;
  assign prow      = (wrap && !last_row) ? cur_row_i + CROW_W'(1) : cur_row_i;
  assign wr_data_o = {item_i.attribute, item_i.char_code};

  always_comb begin
    if (func_e'(item_i.func) == FUNC_PRINT) begin
      sel_col = IDX_W'(pcol);
      sel_row = IDX_W'(prow);
    end else begin
      sel_col = IDX_W'(item_i.column);
      sel_row = IDX_W'(item_i.row);
    end
  end

  assign addr_o = sel_row * IDX_W'(COLUMNS) + sel_col;

  always_comb begin
    plan_o    = '0;
    nxt_col_o = cur_col_i;
    nxt_row_o = cur_row_i;
    unique case (func_e'(item_i.func))
      FUNC_PRINT: begin
        plan_o.wr_en  = 1'b1;
        plan_o.scroll = wrap && last_row;
        plan_o.done   = item_i.last_char;
        nxt_col_o     = pcol + CCOL_W'(1);
        nxt_row_o     = prow;
      end
      FUNC_WRITE: begin
        plan_o.wr_en = on_screen;
        plan_o.done  = 1'b1;
      end
      FUNC_CURSOR: begin
        plan_o.done = 1'b1;
        nxt_col_o   = (item_i.column < COLUMNS) ? CCOL_W'(item_i.column)
                                                : CCOL_W'(COLUMNS - 1);
        nxt_row_o   = (item_i.row < ROWS) ? CROW_W'(item_i.row) : CROW_W'(ROWS - 1);
      end
      FUNC_READ: begin
        plan_o.rd_en = on_screen;
        plan_o.done  = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/text_mode_console_writer.sv */
// Text mode console writer: cell RAM, cursor, scroll sweep and result register.
// Print, write cell and set cursor: result registered, 1 per cycle while the output is free.
// Read cell on screen: registered RAM read port, then ST_READ; off screen: like a write.
// Print that scrolls: ST_SCROLL copies one cell per cycle through the RAM, then ST_PUT.
// Reset: cursor to 0,0; the RAM is cleared one cell per cycle with requests stalled.
`timescale 1ns / 1ps
`default_nettype none

module text_mode_console_writer #(
  parameter int unsigned COLUMNS = tmcw_pkg::COLUMNS_DEF,
  parameter int unsigned ROWS    = tmcw_pkg::ROWS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  tmcw_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output tmcw_pkg::out_item_t out_data_o
);
  import tmcw_pkg::*;

  localparam int unsigned CELLS  = COLUMNS * ROWS;
  localparam int unsigned CCOL_W = $clog2(COLUMNS + 1);
  localparam int unsigned CROW_W = $clog2(ROWS);
  localparam int unsigned IDX_W  = $clog2(CELLS);
  localparam int unsigned CNT_W  = $clog2(CELLS + 1);

  typedef enum logic [4:0] {
    ST_CLEAR  = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_READ   = 5'b00100,
    ST_SCROLL = 5'b01000,
    ST_PUT    = 5'b10000
  } state_e;

  state_e              state_q, state_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [CCOL_W-1:0]   cur_col_q, cur_col_d;
  logic [CROW_W-1:0]   cur_row_q, cur_row_d;
  logic [IDX_W-1:0]    put_addr_q, put_addr_d;
  logic [CELL_W-1:0]   put_data_q, put_data_d;
  logic                put_done_q, put_done_d;
  logic                out_valid_q, out_valid_d;
  out_item_t           out_q, out_d;
  logic [CELL_W-1:0]   rd_q;

  logic [CELL_W-1:0]   mem [CELLS];
  logic                mem_we;
  logic [IDX_W-1:0]    mem_waddr;
  logic [CELL_W-1:0]   mem_wdata;
  logic                mem_re;
  logic [IDX_W-1:0]    mem_raddr;

  plan_t               plan;
  logic [IDX_W-1:0]    plan_addr;
  logic [CELL_W-1:0]   plan_data;
  logic [CCOL_W-1:0]   nxt_col;
  logic [CROW_W-1:0]   nxt_row;

  logic                slot_free;
  logic                accept;
  logic [CNT_W-1:0]    scan_fwd;
  logic [CNT_W-1:0]    scan_prev;

  tmcw_plan #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_plan (
    .item_i    (in_data_i),
    .cur_col_i (cur_col_q),
    .cur_row_i (cur_row_q),
    .plan_o    (plan),
    .addr_o    (plan_addr),
    .wr_data_o (plan_data),
    .nxt_col_o (nxt_col),
    .nxt_row_o (nxt_row)
  );

  assign slot_free  = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == ST_IDLE) && slot_free);
  assign accept     = in_valid_i && !in_stall_o;
  assign scan_fwd   = cnt_q + CNT_W'(COLUMNS);
  assign scan_prev  = cnt_q - CNT_W'(1);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    cur_col_d   = cur_col_q;
    cur_row_d   = cur_row_q;
    put_addr_d  = put_addr_q;
    put_data_d  = put_data_q;
    put_done_d  = put_done_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = '0;
    mem_re      = 1'b0;
    mem_raddr   = '0;

    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_q[IDX_W-1:0];
        if (cnt_q == CNT_W'(CELLS - 1)) begin
          cnt_d   = '0;
          state_d = ST_IDLE;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      ST_IDLE: begin
        if (accept) begin
          cur_col_d = nxt_col;
          cur_row_d = nxt_row;
          if (plan.scroll) begin
            put_addr_d = plan_addr;
            put_data_d = plan_data;
            put_done_d = plan.done;
            cnt_d      = '0;
            state_d    = ST_SCROLL;
          end else if (plan.rd_en) begin
            mem_re    = 1'b1;
            mem_raddr = plan_addr;
            state_d   = ST_READ;
          end else begin
            mem_we      = plan.wr_en;
            mem_waddr   = plan_addr;
            mem_wdata   = plan_data;
            out_valid_d = 1'b1;
            out_d       = '0;
            out_d.cursor_col = COL_FLD_W'(nxt_col);
            out_d.cursor_row = ROW_FLD_W'(nxt_row);
            out_d.done_res   = plan.done;
          end
        end
      end
      ST_READ: begin
        if (slot_free) begin
          out_valid_d      = 1'b1;
          out_d.cursor_col = COL_FLD_W'(cur_col_q);
          out_d.cursor_row = ROW_FLD_W'(cur_row_q);
          out_d.cell_char  = rd_q[BYTE_W-1:0];
          out_d.cell_attr  = rd_q[CELL_W-1:BYTE_W];
          out_d.done_res   = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      ST_SCROLL: begin
        if (cnt_q < CNT_W'(CELLS)) begin
          mem_re    = 1'b1;
          mem_raddr = (cnt_q < CNT_W'(CELLS - COLUMNS)) ? scan_fwd[IDX_W-1:0]
                                                        : cnt_q[IDX_W-1:0];
        end
        if (cnt_q != '0) begin
          mem_we    = 1'b1;
          mem_waddr = scan_prev[IDX_W-1:0];
          mem_wdata = (scan_prev >= CNT_W'(CELLS - COLUMNS))
                    ? {rd_q[CELL_W-1:BYTE_W], BLANK_CHAR} : rd_q;
        end
        if (cnt_q == CNT_W'(CELLS)) begin
          cnt_d   = '0;
          state_d = ST_PUT;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      ST_PUT: begin
        if (slot_free) begin
          mem_we           = 1'b1;
          mem_waddr        = put_addr_q;
          mem_wdata        = put_data_q;
          out_valid_d      = 1'b1;
          out_d            = '0;
          out_d.cursor_col = COL_FLD_W'(cur_col_q);
          out_d.cursor_row = ROW_FLD_W'(cur_row_q);
          out_d.done_res   = put_done_q;
          state_d          = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      cnt_q       <= '0;
      cur_col_q   <= '0;
      cur_row_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      cur_col_q   <= cur_col_d;
      cur_row_q   <= cur_row_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    put_addr_q <= put_addr_d;
    put_data_q <= put_data_d;
    put_done_q <= put_done_d;
    out_q      <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= mem[mem_raddr];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

/* sim/tb_top.sv */
// Testbench for text_mode_console_writer: a directed request table, then random bursts.
// Each result is checked in order against a cell-store and cursor model kept here.
// Depends on tmcw_pkg and the text_mode_console_writer RTL.
`timescale 1ns / 1ps

module tb_top;
  import tmcw_pkg::*;

  localparam int unsigned COLUMNS      = COLUMNS_DEF;
  localparam int unsigned ROWS         = ROWS_DEF;
  localparam int unsigned CELLS        = COLUMNS * ROWS;
  localparam int unsigned QUIET_LIMIT  = 20000;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned RANDOM_ITEMS = 550;

  typedef struct {
    in_item_t  req;
    bit        known;
    out_item_t res;
  } stim_t;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_item_t  in_data_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_data_o;

  logic [CELL_W-1:0] screen_mem [CELLS];
  int unsigned       cur_col;
  int unsigned       cur_row;
  out_item_t         screen_reports_q [$];
  stim_t             directed_q [$];
  int unsigned       send_idle_pct  = 31;
  int unsigned       recv_idle_pct  = 58;
  int unsigned       mismatch_count = 0;
  int unsigned       quiet_cycles   = 0;
  bit                hold_req       = 1'b0;

  text_mode_console_writer DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always #10 clk_i = ~clk_i;

  function automatic in_item_t make_req(input func_e f, input int unsigned col, row, ch, attr,
                                        input bit last);
    in_item_t r;
    r.func      = f;
    r.column    = col[COL_FLD_W-1:0];
    r.row       = row[ROW_FLD_W-1:0];
    r.char_code = ch[BYTE_W-1:0];
    r.attribute = attr[BYTE_W-1:0];
    r.last_char = last;
    return r;
  endfunction

  function automatic out_item_t make_res(input int unsigned col, row, ch, attr, input bit done);
    out_item_t r;
    r.cursor_col = col[COL_FLD_W-1:0];
    r.cursor_row = row[ROW_FLD_W-1:0];
    r.cell_char  = ch[BYTE_W-1:0];
    r.cell_attr  = attr[BYTE_W-1:0];
    r.done_res   = done;
    return r;
  endfunction

  function automatic out_item_t screen_update(input in_item_t req);
    out_item_t   res;
    int unsigned i;
    int unsigned idx;
    res          = '0;
    res.done_res = 1'b1;
    idx          = req.row * COLUMNS + req.column;
    case (func_e'(req.func))
      FUNC_PRINT: begin
        if (cur_col >= COLUMNS) begin
          cur_col = 0;
          if (cur_row >= ROWS - 1) begin
            for (i = 0; i < CELLS - COLUMNS; i++) screen_mem[i] = screen_mem[i + COLUMNS];
            for (i = CELLS - COLUMNS; i < CELLS; i++) screen_mem[i][BYTE_W-1:0] = BLANK_CHAR;
          end else begin
            cur_row++;
          end
        end
        screen_mem[cur_row * COLUMNS + cur_col] = {req.attribute, req.char_code};
        cur_col++;
        res.done_res = req.last_char;
      end
      FUNC_WRITE: begin
        if (req.column < COLUMNS && req.row < ROWS) begin
          screen_mem[idx] = {req.attribute, req.char_code};
        end
      end
      FUNC_CURSOR: begin
        cur_col = (req.column < COLUMNS) ? req.column : COLUMNS - 1;
        cur_row = (req.row < ROWS) ? req.row : ROWS - 1;
      end
      default: begin
        if (req.column < COLUMNS && req.row < ROWS) begin
          res.cell_char = screen_mem[idx][BYTE_W-1:0];
          res.cell_attr = screen_mem[idx][CELL_W-1:BYTE_W];
        end
      end
    endcase
    res.cursor_col = cur_col[COL_FLD_W-1:0];
    res.cursor_row = cur_row[ROW_FLD_W-1:0];
    return res;
  endfunction

  task automatic add_row(input in_item_t req, input bit known, input out_item_t res);
    stim_t s;
    s.req   = req;
    s.known = known;
    s.res   = res;
    directed_q.push_back(s);
  endtask

  task automatic send_request(input in_item_t req, input bit known, input out_item_t known_res);
    out_item_t predicted;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    predicted = screen_update(req);
    screen_reports_q.push_back(known ? known_res : predicted);
  endtask

  task automatic random_phase(input int unsigned target);
    int unsigned n;
    int unsigned kind;
    int unsigned len;
    int unsigned k;
    int unsigned col;
    int unsigned row;
    bit          broken;
    n = 0;
    while (n < target) begin
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
        if ($urandom_range(0, 9) < 7) begin
          col = $urandom_range(0, 1) ? $urandom_range(60, COLUMNS - 1)
                                     : $urandom_range(0, COLUMNS - 1);
          row = $urandom_range(0, 1) ? ROWS - 1 : $urandom_range(0, ROWS - 1);
          send_request(make_req(FUNC_CURSOR, col, row, $urandom, $urandom,
                                $urandom_range(0, 1)), 1'b0, '0);
          n++;
        end
        len    = $urandom_range(1, 24);
        broken = ($urandom_range(0, 9) == 0);
        for (k = 1; k <= len; k++) begin
          send_request(make_req(FUNC_PRINT, $urandom, $urandom, $urandom, $urandom,
                                broken ? $urandom_range(0, 1) : (k == len)), 1'b0, '0);
          n++;
        end
      end else if (kind < 65) begin
        len = $urandom_range(1, 6);
        for (k = 0; k < len; k++) begin
          col = $urandom_range(0, COLUMNS - 1);
          row = $urandom_range(0, ROWS - 1);
          send_request(make_req(FUNC_WRITE, col, row, $urandom, $urandom,
                                $urandom_range(0, 1)), 1'b0, '0);
          send_request(make_req(FUNC_READ, col, row, $urandom, $urandom,
                                $urandom_range(0, 1)), 1'b0, '0);
          n += 2;
        end
      end else if (kind < 85) begin
        col = $urandom_range(0, COLUMNS - 1);
        row = $urandom_range(0, 1) ? cur_row : $urandom_range(0, ROWS - 1);
        send_request(make_req(FUNC_READ, col, row, $urandom, $urandom,
                              $urandom_range(0, 1)), 1'b0, '0);
        n++;
      end else begin
        send_request(make_req(func_e'($urandom_range(0, 3)), $urandom, $urandom, $urandom,
                              $urandom, $urandom_range(0, 1)), 1'b0, '0);
        n++;
      end
    end
  endtask

  task automatic report_mismatch(input string field, input logic [31:0] got, want);
    $display("%0t: mismatch on %s: got 0x%0h, want 0x%0h", $realtime, field, got, want);
    mismatch_count++;
  endtask

  initial begin : rx_stall
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin : result_check
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (screen_reports_q.size() == 0) begin
        report_mismatch("unrequested result", out_data_o, '0);
      end else begin
        want = screen_reports_q.pop_front();
        if (out_data_o.cursor_col !== want.cursor_col)
          report_mismatch("cursor_col", out_data_o.cursor_col, want.cursor_col);
        if (out_data_o.cursor_row !== want.cursor_row)
          report_mismatch("cursor_row", out_data_o.cursor_row, want.cursor_row);
        if (out_data_o.cell_char !== want.cell_char)
          report_mismatch("cell_char", out_data_o.cell_char, want.cell_char);
        if (out_data_o.cell_attr !== want.cell_attr)
          report_mismatch("cell_attr", out_data_o.cell_attr, want.cell_attr);
        if (out_data_o.done_res !== want.done_res)
          report_mismatch("done_res", out_data_o.done_res, want.done_res);
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin : main_flow
    int unsigned r;
    for (r = 0; r < CELLS; r++) screen_mem[r] = '0;
    cur_col = 0;
    cur_row = 0;

    add_row(make_req(FUNC_READ,   0,   0,    0,    0, 0), 1, make_res( 0,  0,    0,    0, 1));
    add_row(make_req(FUNC_READ,  79,  24, 8'hFF, 8'hFF, 1), 1, make_res(0, 0, 0, 0, 1));
    add_row(make_req(FUNC_READ, 127,  31,    0,    0, 0), 1, make_res( 0,  0,    0,    0, 1));
    add_row(make_req(FUNC_PRINT, 127, 31, 8'hFF, 8'hFF, 0), 1, make_res(1, 0, 0, 0, 0));
    add_row(make_req(FUNC_READ,   0,   0,    0,    0, 0), 1, make_res(1, 0, 8'hFF, 8'hFF, 1));
    add_row(make_req(FUNC_WRITE, 79,  24, 8'hA5, 8'h5A, 0), 1, make_res(1, 0, 0, 0, 1));
    add_row(make_req(FUNC_WRITE, 80,   0, 8'h11, 8'h22, 0), 1, make_res(1, 0, 0, 0, 1));
    add_row(make_req(FUNC_WRITE,  0,  25, 8'h33, 8'h44, 1), 1, make_res(1, 0, 0, 0, 1));
    add_row(make_req(FUNC_READ,  79,  24,    0,    0, 0), 1, make_res(1, 0, 8'hA5, 8'h5A, 1));
    add_row(make_req(FUNC_CURSOR, 127, 31,   0,    0, 0), 1, make_res(79, 24, 0, 0, 1));
    add_row(make_req(FUNC_PRINT,  0,   0, 8'h41, 8'h07, 1), 1, make_res(80, 24, 0, 0, 1));
    add_row(make_req(FUNC_READ,  79,  24,    0,    0, 0), 1, make_res(80, 24, 8'h41, 8'h07, 1));
    add_row(make_req(FUNC_PRINT,  0,   0, 8'h42, 8'h1F, 0), 0, '0);
    add_row(make_req(FUNC_READ,   0,  24,    0,    0, 0), 0, '0);
    add_row(make_req(FUNC_READ,  79,  24,    0,    0, 0), 0, '0);
    add_row(make_req(FUNC_READ,  79,  23,    0,    0, 0), 0, '0);
    add_row(make_req(FUNC_CURSOR, 79,  0,    0,    0, 0), 1, make_res(79, 0, 0, 0, 1));
    add_row(make_req(FUNC_PRINT,  0,   0,    0,    0, 1), 1, make_res(80, 0, 0, 0, 1));
    add_row(make_req(FUNC_PRINT,  0,   0, 8'hFF,    0, 0), 0, '0);
    add_row(make_req(FUNC_READ,   0,   1,    0,    0, 0), 0, '0);
    add_row(make_req(FUNC_CURSOR, 80, 24,    0,    0, 0), 0, '0);
    add_row(make_req(FUNC_CURSOR,  5, 31,    0,    0, 0), 0, '0);
    add_row(make_req(FUNC_READ,   0,  25,    0,    0, 0), 0, '0);
    add_row(make_req(FUNC_READ,  80,   0,    0,    0, 0), 0, '0);
    add_row(make_req(FUNC_WRITE, 127, 31, 8'hFF, 8'hFF, 1), 0, '0);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (r = 0; r < directed_q.size(); r++) begin
      send_request(directed_q[r].req, directed_q[r].known, directed_q[r].res);
    end
    random_phase(RANDOM_ITEMS / 3);
    send_idle_pct = 58;
    recv_idle_pct = 31;
    random_phase(RANDOM_ITEMS / 3);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req      = 1'b1;
    random_phase(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));
    in_valid_i <= 1'b0;

    while (screen_reports_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/tmcw_pkg.sv
rtl/tmcw_plan.sv
rtl/text_mode_console_writer.sv
sim/tb_top.sv
